### src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/cpc_pkg.sv
`default_nettype none

package cpc_pkg;

  localparam int ANGLE_BITS   = 16;
  localparam int POS_BITS     = 32;
  localparam int CORDIC_STEPS = 16;

  localparam int FULL_STEPS = 24;
  localparam int IDX_BITS   = $clog2(FULL_STEPS);

  localparam int LEN_BITS  = 16;
  localparam int TURN_BITS = 16;
  localparam int CFG_BITS  = 32;
  localparam int ADDR_BITS = 2;

  localparam int XY_BITS     = 34;
  localparam int PROD_BITS   = LEN_BITS + 1 + XY_BITS;
  localparam int ROUND_SHIFT = 22;
  localparam int STEP_BITS   = PROD_BITS - ROUND_SHIFT;
  localparam int EXT_BITS    = ((POS_BITS > CFG_BITS) ? POS_BITS : CFG_BITS) + 2;

  localparam int IN_TDATA_BITS  = ((LEN_BITS + TURN_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 2 * POS_BITS + ANGLE_BITS;
  localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic signed [XY_BITS-1:0] CORDIC_GAIN = XY_BITS'(652032874);
  localparam logic signed [XY_BITS-1:0] QUARTER     = XY_BITS'(64'sd1 <<< 30);
  localparam logic signed [XY_BITS-1:0] HALF        = XY_BITS'(64'sd1 <<< 31);
  localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
    PROD_BITS'(64'sd1 <<< (ROUND_SHIFT - 1));

  localparam logic signed [EXT_BITS-1:0] POS_MAX =
    EXT_BITS'((64'sd1 <<< (POS_BITS - 1)) - 64'sd1);
  localparam logic signed [EXT_BITS-1:0] POS_MIN = -POS_MAX - EXT_BITS'(1);

  typedef enum logic [ADDR_BITS-1:0] {
    REG_START_HEADING = 2'd0,
    REG_START_X       = 2'd1,
    REG_START_Y       = 2'd2
  } cpc_reg_t;

  typedef struct packed {
    logic                capture;
    logic                prep;
    logic                emit_start;
    logic                init;
    logic                iter;
    logic [IDX_BITS-1:0] idx;
    logic                mul_x;
    logic                mul_y;
    logic                acc;
    logic                emit_end;
  } cpc_cmd_t;

  typedef struct packed {
    logic first;
    logic out_free;
  } cpc_status_t;

  typedef struct packed {
    logic [POS_BITS-1:0] value;
    logic                sat;
  } cpc_pos_t;

  function automatic logic [31:0] atan_entry(input logic [IDX_BITS-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41721;
      5'd15:   r = 32'd20860;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2607;
      5'd19:   r = 32'd1303;
      5'd20:   r = 32'd651;
      5'd21:   r = 32'd325;
      5'd22:   r = 32'd162;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

  function automatic cpc_pos_t clamp_pos(input logic signed [EXT_BITS-1:0] v);
    cpc_pos_t r;
    if (v > POS_MAX) begin
      r.value = POS_MAX[POS_BITS-1:0];
      r.sat   = 1'b1;
    end else if (v < POS_MIN) begin
      r.value = POS_MIN[POS_BITS-1:0];
      r.sat   = 1'b1;
    end else begin
      r.value = v[POS_BITS-1:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction

  function automatic logic signed [STEP_BITS-1:0] round_step(
    input logic signed [PROD_BITS-1:0] p
  );
    logic signed [PROD_BITS-1:0] t;
    t = p + ROUND_HALF;
    return t[PROD_BITS-1:ROUND_SHIFT];
  endfunction

endpackage

`default_nettype wire

### src/cpc_ctrl.sv
`default_nettype none
`include "assert_macros.svh"

module cpc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire cpc_pkg::cpc_status_t status,
  output cpc_pkg::cpc_cmd_t         cmd
);
  import cpc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_START,
    S_INIT,
    S_ITER,
    S_MULX,
    S_MULY,
    S_ACC,
    S_END
  } state_t;

  localparam logic [IDX_BITS-1:0] ITER_LAST = IDX_BITS'(CORDIC_STEPS - 1);

  state_t              state;
  state_t              state_next;
  logic [IDX_BITS-1:0] iter_cnt;
  logic [IDX_BITS-1:0] iter_cnt_next;
  logic [8:0]          cmd_flags;

  always_comb begin
    state_next    = state;
    iter_cnt_next = iter_cnt;
    cmd           = '0;
    cmd.idx       = iter_cnt;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = status.first ? S_START : S_INIT;
      end
      S_START: begin
        if (status.out_free) begin
          cmd.emit_start = 1'b1;
          state_next     = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init      = 1'b1;
        iter_cnt_next = '0;
        state_next    = S_ITER;
      end
      S_ITER: begin
        cmd.iter = 1'b1;
        if (iter_cnt == ITER_LAST) begin
          state_next = S_MULX;
        end else begin
          iter_cnt_next = iter_cnt + IDX_BITS'(1);
        end
      end
      S_MULX: begin
        cmd.mul_x  = 1'b1;
        state_next = S_MULY;
      end
      S_MULY: begin
        cmd.mul_y  = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_END;
      end
      S_END: begin
        if (status.out_free) begin
          cmd.emit_end = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      iter_cnt <= '0;
    end else begin
      state    <= state_next;
      iter_cnt <= iter_cnt_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign cmd_flags = {cmd.capture, cmd.prep, cmd.emit_start, cmd.init, cmd.iter,
                      cmd.mul_x, cmd.mul_y, cmd.acc, cmd.emit_end};

  `ASSERT_CLK(a_cmd_onehot, $onehot0(cmd_flags), "more than one datapath command")
  `ASSERT_CLK(a_emit_free, (cmd.emit_start || cmd.emit_end) |-> status.out_free,
              "result loaded while output register is occupied")
  `ASSERT_CLK(a_iter_done, (state == S_ITER && iter_cnt == ITER_LAST) |=> (state == S_MULX),
              "rotation did not stop after the last step")
  `ASSERT_CLK_ALWAYS(a_reset_idle, rst |=> (state == S_IDLE), "reset did not return to idle")

endmodule

`default_nettype wire

### src/cpc_datapath.sv
`default_nettype none

module cpc_datapath (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [cpc_pkg::ADDR_BITS-1:0]  cfg_addr,
  input  wire logic [cpc_pkg::CFG_BITS-1:0]   cfg_data,
  input  wire logic [cpc_pkg::LEN_BITS-1:0]   seg_length,
  input  wire logic [cpc_pkg::TURN_BITS-1:0]  turn,
  input  wire logic                           first_seg,
  input  wire logic                           last_seg,
  input  wire cpc_pkg::cpc_cmd_t              cmd,
  output cpc_pkg::cpc_status_t                status,
  input  wire logic                           out_ready,
  output logic                                out_valid,
  output logic [cpc_pkg::POS_BITS-1:0]        point_x,
  output logic [cpc_pkg::POS_BITS-1:0]        point_y,
  output logic [cpc_pkg::ANGLE_BITS-1:0]      heading,
  output logic                                saturated,
  output logic                                end_of_curve
);
  import cpc_pkg::*;

  logic [15:0]                  start_heading;
  logic signed [CFG_BITS-1:0]   start_x;
  logic signed [CFG_BITS-1:0]   start_y;

  logic [LEN_BITS-1:0]          len_r;
  logic signed [TURN_BITS-1:0]  turn_r;
  logic                         first_r;
  logic                         last_r;

  logic [ANGLE_BITS-1:0]        cur_heading;
  logic signed [POS_BITS-1:0]   cur_x;
  logic signed [POS_BITS-1:0]   cur_y;
  logic                         start_sat;
  logic                         end_sat;

  logic signed [XY_BITS-1:0]    cx;
  logic signed [XY_BITS-1:0]    cy;
  logic signed [XY_BITS-1:0]    cz;
  logic signed [PROD_BITS-1:0]  prod;
  logic signed [STEP_BITS-1:0]  step_x;

  logic signed [XY_BITS-1:0]    z_init;
  logic signed [XY_BITS-1:0]    atan_val;
  logic signed [XY_BITS-1:0]    xs;
  logic signed [XY_BITS-1:0]    ys;
  logic signed [LEN_BITS:0]     len_s;
  logic signed [EXT_BITS-1:0]   sum_x;
  logic signed [EXT_BITS-1:0]   sum_y;
  cpc_pos_t                     load_x;
  cpc_pos_t                     load_y;
  cpc_pos_t                     new_x;
  cpc_pos_t                     new_y;

  assign z_init   = XY_BITS'($signed({cur_heading, (32 - ANGLE_BITS)'(0)}));
  assign atan_val = $signed({(XY_BITS - 32)'(0), atan_entry(cmd.idx)});
  assign xs       = cx >>> cmd.idx;
  assign ys       = cy >>> cmd.idx;
  assign len_s    = $signed({1'b0, len_r});
  assign load_x   = clamp_pos(EXT_BITS'(start_x));
  assign load_y   = clamp_pos(EXT_BITS'(start_y));
  assign sum_x    = EXT_BITS'(cur_x) + EXT_BITS'(step_x);
  assign sum_y    = EXT_BITS'(cur_y) + EXT_BITS'(round_step(prod));
  assign new_x    = clamp_pos(sum_x);
  assign new_y    = clamp_pos(sum_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_heading <= '0;
      start_x       <= '0;
      start_y       <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_START_HEADING: start_heading <= cfg_data[15:0];
        REG_START_X:       start_x       <= cfg_data;
        REG_START_Y:       start_y       <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      len_r   <= seg_length;
      turn_r  <= turn;
      first_r <= first_seg;
      last_r  <= last_seg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_heading <= '0;
      cur_x       <= '0;
      cur_y       <= '0;
    end else if (cmd.prep) begin
      if (first_r) begin
        cur_heading <= ANGLE_BITS'(start_heading);
        cur_x       <= load_x.value;
        cur_y       <= load_y.value;
      end else begin
        cur_heading <= cur_heading + ANGLE_BITS'(turn_r);
      end
    end else if (cmd.acc) begin
      cur_x <= new_x.value;
      cur_y <= new_y.value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      start_sat <= load_x.sat | load_y.sat;
    end
    if (cmd.acc) begin
      end_sat <= new_x.sat | new_y.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      if (z_init > QUARTER) begin
        cz <= z_init - HALF;
        cx <= -CORDIC_GAIN;
      end else if (z_init < -QUARTER) begin
        cz <= z_init + HALF;
        cx <= -CORDIC_GAIN;
      end else begin
        cz <= z_init;
        cx <= CORDIC_GAIN;
      end
      cy <= '0;
    end else if (cmd.iter) begin
      if (!cz[XY_BITS-1]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - atan_val;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + atan_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_x) begin
      prod <= len_s * cx;
    end else if (cmd.mul_y) begin
      step_x <= round_step(prod);
      prod   <= len_s * cy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_start || cmd.emit_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_start || cmd.emit_end) begin
      point_x      <= cur_x;
      point_y      <= cur_y;
      heading      <= cur_heading;
      saturated    <= cmd.emit_start ? start_sat : end_sat;
      end_of_curve <= cmd.emit_end & last_r;
    end
  end

  assign status.first    = first_r;
  assign status.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

### src/curvature_to_planar_curve.sv
// Per segment: the transaction is captured, then the heading is advanced by turn, or on a first
// segment the start pose is loaded and its start point goes into the output register; the end
// point follows the 16-step shared CORDIC rotator, the single multiplier used for x then y, and
// the accumulate. A new segment is accepted only when idle; output stalls hold both loads.
// Reset (rst, synchronous): heading, position and start registers clear to zero, no result pending.
`default_nettype none

module curvature_to_planar_curve (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [cpc_pkg::ADDR_BITS-1:0]       cfg_addr,
  input  wire logic [cpc_pkg::CFG_BITS-1:0]        cfg_data,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  input  wire logic [cpc_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,  // seg_length, turn
  input  wire logic                                s_axis_tlast,  // last_seg
  input  wire logic                                s_axis_tuser,  // first_seg
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output logic [cpc_pkg::OUT_TDATA_BITS-1:0]       m_axis_tdata,  // point_x, point_y, heading
  output logic                                     m_axis_tlast,  // end_of_curve
  output logic                                     m_axis_tuser   // saturated
);
  import cpc_pkg::*;

  cpc_cmd_t              cmd;
  cpc_status_t           status;
  logic [POS_BITS-1:0]   point_x;
  logic [POS_BITS-1:0]   point_y;
  logic [ANGLE_BITS-1:0] heading;

  cpc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  cpc_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .seg_length   (s_axis_tdata[LEN_BITS-1:0]),
    .turn         (s_axis_tdata[LEN_BITS +: TURN_BITS]),
    .first_seg    (s_axis_tuser),
    .last_seg     (s_axis_tlast),
    .cmd          (cmd),
    .status       (status),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .point_x      (point_x),
    .point_y      (point_y),
    .heading      (heading),
    .saturated    (m_axis_tuser),
    .end_of_curve (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDATA_BITS'({heading, point_y, point_x});

endmodule

`default_nettype wire
